FILE: sv/tslv_pkg.sv
package tslv_pkg;

  // register map, index = paddr[3:2]
  localparam logic [1:0] REG_LIGHT_X = 2'd0;
  localparam logic [1:0] REG_LIGHT_Y = 2'd1;
  localparam logic [1:0] REG_LIGHT_Z = 2'd2;

  localparam logic [31:0] LIGHT_Z_RESET = 32'd32768000;

  // pipeline geometry
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned DIV_STEPS  = 31;
  localparam int unsigned SQRT_BASE  = 4;
  localparam int unsigned DIV_BASE   = SQRT_BASE + SQRT_STEPS;
  localparam int unsigned PROD_POS   = DIV_BASE + DIV_STEPS;
  localparam int unsigned SIDE_DEPTH = PROD_POS + 1;

  // partial state of one square root cell
  typedef struct packed {
    logic [61:0] rem;
    logic [62:0] root;
  } sqrt_state_t;

  // partial state of one divider cell, three lanes
  typedef struct packed {
    logic [2:0][30:0] rem;
    logic [2:0][30:0] quo;
    logic [30:0]      den;
  } div_state_t;

  // per-item data that travels beside the arithmetic
  typedef struct packed {
    logic                   valid;
    logic                   zero;
    logic [2:0]             neg;
    logic [2:0][29:0]       mag;
    logic [8:0][15:0]       vec;
  } side_t;

endpackage

FILE: sv/tslv_sqrt_cell.sv
module tslv_sqrt_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic                  clk,
  input  logic                  en,
  input  tslv_pkg::sqrt_state_t din,
  output tslv_pkg::sqrt_state_t dout
);
  import tslv_pkg::*;

  localparam logic [62:0] BIT = 63'(1) << (62 - 2 * STEP);

  logic [63:0] trial;
  logic        take;
  sqrt_state_t nxt;

  // one digit of the bitwise square root
  always_comb begin
    trial = {1'b0, din.root} + {1'b0, BIT};
    take  = {2'b00, din.rem} >= trial;
    if (take) begin
      nxt.rem  = 62'({2'b00, din.rem} - trial);
      nxt.root = (din.root >> 1) + BIT;
    end else begin
      nxt.rem  = din.rem;
      nxt.root = din.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule

FILE: sv/tslv_div_cell.sv
module tslv_div_cell (
  input  logic                 clk,
  input  logic                 en,
  input  logic [2:0]           nbit,
  input  tslv_pkg::div_state_t din,
  output tslv_pkg::div_state_t dout
);
  import tslv_pkg::*;

  logic [2:0][31:0] trial;
  logic [2:0]       ge;
  div_state_t       nxt;

  // one restoring quotient bit per lane
  always_comb begin
    nxt.den = din.den;
    for (int i = 0; i < 3; i++) begin
      trial[i]   = {din.rem[i], nbit[i]};
      ge[i]      = trial[i] >= {1'b0, din.den};
      nxt.rem[i] = ge[i] ? 31'(trial[i] - {1'b0, din.den}) : trial[i][30:0];
      nxt.quo[i] = {din.quo[i][29:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule

FILE: sv/tangent_space_light_vector_unit.sv
// throughput: one vertex per cycle while the output is taken
// the whole pipeline holds when a result waits and m_tready is low
// reset clears all valid flags and loads the light position (0, 0, LIGHT_Z_RESET)
module tangent_space_light_vector_unit (
  input  logic         clk,
  input  logic         rst,
  // pos_x, pos_y, pos_z, tan_x..z, bin_x..z, nrm_x..z from bit 0 up
  input  logic [239:0] s_tdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  // light_t, light_b, light_n from bit 0 up
  output logic [47:0]  m_tdata,
  // zero_length
  output logic         m_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import tslv_pkg::*;

  logic        en;
  logic [31:0] light_x, light_y, light_z;
  side_t       side [SIDE_DEPTH];

  // configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      light_x <= '0;
      light_y <= '0;
      light_z <= LIGHT_Z_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_LIGHT_X: light_x <= pwdata;
        REG_LIGHT_Y: light_y <= pwdata;
        REG_LIGHT_Z: light_z <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_LIGHT_X: prdata = light_x;
      REG_LIGHT_Y: prdata = light_y;
      REG_LIGHT_Z: prdata = light_z;
      default:     prdata = '0;
    endcase
  end

  // global advance
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // difference to light, magnitude and sign
  logic [2:0][31:0] lp, ps;
  logic [2:0][33:0] diff;
  logic [2:0][32:0] mag_in;
  logic [2:0]       neg_in;

  always_comb begin
    lp = {light_z, light_y, light_x};
    ps = s_tdata[95:0];
    for (int i = 0; i < 3; i++) begin
      diff[i]   = {{2{lp[i][31]}}, lp[i]} - {{2{ps[i][31]}}, ps[i]};
      neg_in[i] = diff[i][33];
      mag_in[i] = neg_in[i] ? 33'(-diff[i]) : diff[i][32:0];
    end
  end

  logic [2:0][32:0] mag_cap;

  always_ff @(posedge clk) begin
    if (en) begin
      mag_cap <= mag_in;
    end
  end

  // scale so the largest magnitude is below 2^30
  logic [32:0]      mx;
  logic [1:0]       shk;
  logic [2:0][29:0] mag_sh;

  always_comb begin
    mx = mag_cap[0];
    if (mag_cap[1] > mx) mx = mag_cap[1];
    if (mag_cap[2] > mx) mx = mag_cap[2];
    priority if (mx[32]) shk = 2'd3;
    else if (mx[31])     shk = 2'd2;
    else if (mx[30])     shk = 2'd1;
    else                 shk = 2'd0;
    for (int i = 0; i < 3; i++) begin
      mag_sh[i] = 30'(mag_cap[i] >> shk);
    end
  end

  // side line, mags and zero flag fill in on the way
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SIDE_DEPTH; i++) begin
        side[i].valid <= 1'b0;
      end
    end else if (en) begin
      side[0].valid <= s_tvalid;
      side[0].zero  <= 1'b0;
      side[0].neg   <= neg_in;
      side[0].mag   <= '0;
      side[0].vec   <= s_tdata[239:96];
      side[1].valid <= side[0].valid;
      side[1].zero  <= side[0].zero;
      side[1].neg   <= side[0].neg;
      side[1].mag   <= mag_sh;
      side[1].vec   <= side[0].vec;
      side[2].valid <= side[1].valid;
      side[2].zero  <= (side[1].mag == '0);
      side[2].neg   <= side[1].neg;
      side[2].mag   <= side[1].mag;
      side[2].vec   <= side[1].vec;
      for (int i = 3; i < SIDE_DEPTH; i++) begin
        side[i] <= side[i-1];
      end
    end
  end

  // squares and their sum
  logic [2:0][59:0] sq;
  logic [61:0]      ssum;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq[i] <= side[1].mag[i] * side[1].mag[i];
      end
      ssum <= 62'(sq[0]) + 62'(sq[1]) + 62'(sq[2]);
    end
  end

  // square root chain
  sqrt_state_t sq_chain [SQRT_STEPS + 1];

  assign sq_chain[0].rem  = ssum;
  assign sq_chain[0].root = '0;

  for (genvar c = 0; c < SQRT_STEPS; c++) begin : g_sqrt
    tslv_sqrt_cell #(.STEP(c)) u_cell (
      .clk  (clk),
      .en   (en),
      .din  (sq_chain[c]),
      .dout (sq_chain[c+1])
    );
  end

  // divider chain, quotient = mag * 2^30 / length
  div_state_t dv_chain [DIV_STEPS + 1];
  logic [2:0] first_bit;

  always_comb begin
    dv_chain[0].den = sq_chain[SQRT_STEPS].root[30:0];
    for (int i = 0; i < 3; i++) begin
      dv_chain[0].rem[i] = 31'(side[DIV_BASE-1].mag[i] >> 1);
      dv_chain[0].quo[i] = '0;
      first_bit[i]       = side[DIV_BASE-1].mag[i][0];
    end
  end

  for (genvar c = 0; c < DIV_STEPS; c++) begin : g_div
    tslv_div_cell u_cell (
      .clk  (clk),
      .en   (en),
      .nbit ((c == 0) ? first_bit : 3'b000),
      .din  (dv_chain[c]),
      .dout (dv_chain[c+1])
    );
  end

  // signed unit vector times basis vectors
  logic signed [2:0][31:0]      unit;
  logic signed [2:0][2:0][47:0] prod;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      unit[i] = side[PROD_POS-1].neg[i] ? -{1'b0, dv_chain[DIV_STEPS].quo[i]}
                                       : {1'b0, dv_chain[DIV_STEPS].quo[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          prod[j][i] <= $signed(unit[i]) * $signed(side[PROD_POS-1].vec[3*j+i]);
        end
      end
    end
  end

  // sum, round half up, saturate; zero for a zero length
  logic signed [49:0] acc [3];
  logic signed [19:0] qv  [3];
  logic [2:0][15:0]   res;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      acc[j] = 50'($signed(prod[j][0])) + 50'($signed(prod[j][1]))
             + 50'($signed(prod[j][2])) + 50'sd536870912;
      qv[j]  = acc[j][49:30];
      priority if (qv[j] > 20'sd32767)   res[j] = 16'h7fff;
      else if (qv[j] < -20'sd32768)      res[j] = 16'h8000;
      else                               res[j] = qv[j][15:0];
      if (side[PROD_POS].zero) res[j] = '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= side[PROD_POS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= res;
      m_tuser <= side[PROD_POS].zero;
    end
  end

endmodule

FILE: sv/tslv_check.sv
module tslv_check (
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic [47:0]  m_tdata,
  input logic         m_tuser,
  input logic         m_tvalid,
  input logic         m_tready
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // input side is open unless a result waits
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("s_tready does not follow output stall");

  // coincident vertex gives zero vector
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("zero length result not zero");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind tangent_space_light_vector_unit tslv_check u_tslv_check (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);

FILE: verif/tb_tangent_space_light_vector_unit.sv
module tb_tangent_space_light_vector_unit;
  import tslv_pkg::*;

  localparam logic [1:0] REG_UNMAPPED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PIPE_LATENCY = 68;

  typedef struct packed {
    logic [15:0] t;
    logic [15:0] b;
    logic [15:0] n;
    logic        zero;
  } light_dir_t;

  logic         clk;
  logic         rst;
  logic [239:0] s_tdata;
  logic         s_tvalid;
  logic         s_tready;
  logic [47:0]  m_tdata;
  logic         m_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [3:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  tangent_space_light_vector_unit dut (.*);

  // vertices waiting to be sent, light directions waiting to arrive
  logic [239:0] vertex_q[$];
  light_dir_t   light_dir_q[$];
  logic [31:0]  light_pos[3];
  int           err_cnt;
  int           cycle_cnt;
  bit           no_idle;
  bit           hold_start;
  int           hold_cnt;
  bit           in_done;

  // clock
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned r;
    longint unsigned bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= r + bitv) begin
        s = s - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  // dot of a Q2.30 unit vector with a Q2.14 vector, rounded and saturated
  function automatic logic [15:0] dot_sat(longint u[3], logic [47:0] v);
    longint sum;
    longint q;
    sum = 0;
    for (int i = 0; i < 3; i++) sum += u[i] * longint'($signed(v[16*i +: 16]));
    q = (sum + (64'sd1 <<< 29)) >>> 30;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  // tangent space light direction for one vertex
  function automatic light_dir_t tangent_light(logic [239:0] vtx);
    longint          d;
    longint unsigned mag[3];
    bit              neg[3];
    longint          u[3];
    longint unsigned mx;
    longint unsigned s;
    longint unsigned len;
    longint unsigned q;
    int              k;
    light_dir_t      r;
    mx = 0;
    s = 0;
    k = 0;
    for (int i = 0; i < 3; i++) begin
      d = longint'($signed(light_pos[i])) - longint'($signed(vtx[32*i +: 32]));
      neg[i] = d < 0;
      mag[i] = neg[i] ? -d : d;
      if (mag[i] > mx) mx = mag[i];
    end
    while ((mx >> k) >= (64'd1 << 30)) k++;
    for (int i = 0; i < 3; i++) begin
      mag[i] = mag[i] >> k;
      s += mag[i] * mag[i];
    end
    if (s == 0) begin
      r = '0;
      r.zero = 1'b1;
      return r;
    end
    len = int_sqrt(s);
    for (int i = 0; i < 3; i++) begin
      q = (mag[i] << 30) / len;
      u[i] = neg[i] ? -longint'(q) : longint'(q);
    end
    r.t = dot_sat(u, vtx[96 +: 48]);
    r.b = dot_sat(u, vtx[144 +: 48]);
    r.n = dot_sat(u, vtx[192 +: 48]);
    r.zero = 1'b0;
    return r;
  endfunction

  function automatic logic [239:0] pack_vertex(logic [31:0] px, logic [31:0] py,
                                               logic [31:0] pz, logic [143:0] vecs);
    return {vecs, pz, py, px};
  endfunction

  function automatic logic [143:0] rand_vecs();
    logic [143:0] v;
    for (int i = 0; i < 9; i++) begin
      if ($urandom_range(1)) v[16*i +: 16] = $urandom;
      else v[16*i +: 16] = 16'($signed($urandom_range(32768)) - 16384);
    end
    return v;
  endfunction

  // mostly vertices near the light, some anywhere, a few on it
  function automatic logic [239:0] rand_vertex();
    logic [31:0] p[3];
    int          sel;
    sel = $urandom_range(99);
    for (int i = 0; i < 3; i++) begin
      if (sel < 4) p[i] = light_pos[i];
      else if (sel < 70) p[i] = light_pos[i] + ($urandom_range(1) ?
                                 32'($urandom_range(1 << 22)) - (1 << 21) :
                                 32'($urandom_range(64)) - 32);
      else p[i] = $urandom;
    end
    return pack_vertex(p[0], p[1], p[2], rand_vecs());
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_cnt);
    err_cnt++;
  endtask

  task automatic write_light(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    if (idx != REG_UNMAPPED) light_pos[idx] = val;
  endtask

  task automatic set_light(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    write_light(REG_LIGHT_X, x);
    write_light(REG_LIGHT_Y, y);
    write_light(REG_LIGHT_Z, z);
  endtask

  // wait until every vertex is taken and every result has come back
  task automatic drain();
    while (vertex_q.size() != 0 || s_tvalid || light_dir_q.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 4) @(posedge clk);
  endtask

  task automatic push_random(int n);
    repeat (n) vertex_q.push_back(rand_vertex());
  endtask

  // cycle limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // input transfer: record the expected light direction
  always @(posedge clk) begin
    in_done <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) begin
      light_dir_q.push_back(tangent_light(s_tdata));
      void'(vertex_q.pop_front());
    end
  end

  // sender, moves on only after a transfer at the last edge
  always @(negedge clk) begin
    if (!rst && (!s_tvalid || in_done)) begin
      if (vertex_q.size() != 0 && (no_idle || $urandom_range(99) >= 11)) begin
        s_tdata <= vertex_q[0];
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver, with an occasional long hold-off
  always @(negedge clk) begin
    if (hold_start) begin
      hold_cnt = 300;
      hold_start = 1'b0;
    end
    if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= no_idle || $urandom_range(99) >= 11;
    end
  end

  // output transfer check
  always @(posedge clk) begin
    light_dir_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (light_dir_q.size() == 0) begin
        $display("unexpected result at cycle %0d", cycle_cnt);
        err_cnt++;
      end else begin
        want = light_dir_q.pop_front();
        if (m_tdata[15:0] !== want.t) report_mismatch("light_t", m_tdata[15:0], want.t);
        if (m_tdata[31:16] !== want.b) report_mismatch("light_b", m_tdata[31:16], want.b);
        if (m_tdata[47:32] !== want.n) report_mismatch("light_n", m_tdata[47:32], want.n);
        if (m_tuser !== want.zero) report_mismatch("zero_length", 16'(m_tuser), 16'(want.zero));
      end
    end
  end

  initial begin
    logic [143:0] maxv;
    logic [143:0] minv;
    err_cnt = 0;
    no_idle = 1'b0;
    hold_start = 1'b0;
    hold_cnt = 0;
    rst = 1'b1;
    s_tdata = '0;
    s_tvalid = 1'b0;
    m_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    light_pos[0] = '0;
    light_pos[1] = '0;
    light_pos[2] = LIGHT_Z_RESET;
    maxv = {9{16'h7fff}};
    minv = {9{16'h8000}};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset light position, directed vertices
    vertex_q.push_back(pack_vertex(0, 0, LIGHT_Z_RESET, rand_vecs()));
    vertex_q.push_back(pack_vertex(0, 0, 0, maxv));
    vertex_q.push_back(pack_vertex(0, 0, 0, minv));
    vertex_q.push_back(pack_vertex(0, 0, 0, {3{16'h4000, 16'h0000, 16'h0000}}));
    vertex_q.push_back(pack_vertex(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, maxv));
    vertex_q.push_back(pack_vertex(32'h80000000, 32'h80000000, 32'h80000000, minv));
    vertex_q.push_back(pack_vertex(32'h80000000, 0, 32'h7fffffff, {9{16'hffff}}));
    vertex_q.push_back(pack_vertex(32'h1, 32'h0, LIGHT_Z_RESET, maxv));
    vertex_q.push_back(pack_vertex(32'hffffffff, 32'h0, LIGHT_Z_RESET, '0));
    push_random(60);
    drain();

    // light at the top corner; far vertex needs the widest difference
    set_light(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    vertex_q.push_back(pack_vertex(32'h80000000, 32'h80000000, 32'h80000000, maxv));
    vertex_q.push_back(pack_vertex(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, maxv));
    vertex_q.push_back(pack_vertex(32'h80000000, 32'h7fffffff, 32'h7fffffff, minv));
    push_random(60);
    drain();

    // light at the bottom corner, unmapped register written too
    set_light(32'h80000000, 32'h80000000, 32'h80000000);
    write_light(REG_UNMAPPED, 32'h12345678);
    vertex_q.push_back(pack_vertex(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, minv));
    vertex_q.push_back(pack_vertex(32'h80000000, 32'h80000000, 32'h80000000, maxv));
    push_random(60);
    drain();

    // receiver holds off while the sender keeps offering
    set_light($urandom, $urandom, $urandom);
    hold_start = 1'b1;
    push_random(150);
    drain();

    // random lights; one stretch with no idling
    for (int ph = 0; ph < 4; ph++) begin
      set_light($urandom, $urandom, $urandom);
      no_idle = (ph == 1);
      push_random(70);
      drain();
    end
    no_idle = 1'b0;

    // back to a small light position
    set_light(32'h0, 32'h0, LIGHT_Z_RESET);
    push_random(40);
    drain();

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/tslv_pkg.sv
sv/tslv_sqrt_cell.sv
sv/tslv_div_cell.sv
sv/tangent_space_light_vector_unit.sv
sv/tslv_check.sv
verif/tb_tangent_space_light_vector_unit.sv
